// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define I2C_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define I2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/i2c_mbe_pkg.sv =====
// Package with the command codes, constants and word types of the I2C byte engine.
package i2c_mbe_pkg;

  // Command codes carried in the mode field.
  localparam logic [2:0] CMD_IDLE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ_ACK = 3'd4;
  localparam logic [2:0] CMD_READ_NAK = 3'd5;

  // Number of delay slots of each command.
  localparam logic [4:0] SLOTS_START_STOP = 5'd3;
  localparam logic [4:0] SLOTS_WRITE      = 5'd27;
  localparam logic [4:0] SLOTS_READ       = 5'd28;

  // Slot numbers with a special action.
  localparam logic [4:0] SLOT_WR_RELEASE = 5'd24;
  localparam logic [4:0] SLOT_WR_ACK     = 5'd25;
  localparam logic [4:0] SLOT_RD_LAST    = 5'd24;
  localparam logic [4:0] SLOT_RD_ACK     = 5'd25;
  localparam logic [4:0] SLOT_RD_CLK_HI  = 5'd26;

  // Register map.
  localparam logic       REG_DELAY_TICKS = 1'b0;
  localparam logic [15:0] DELAY_RESET    = 16'd55;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       acked;
    logic [7:0] read_byte;
  } res_t;

endpackage

// ===== hw/rtl/i2c_mbe_seq.sv =====
// Pin sequencer of the I2C byte engine: command state, slot timing and pin actions.
module i2c_mbe_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  i2c_mbe_pkg::item_t   item_i,
  input  logic [15:0]          delay_ticks_i,
  output i2c_mbe_pkg::res_t    res_o
);

  typedef struct packed {
    logic [2:0] bit_idx;
    logic [1:0] phase;
  } bitpos_t;

  // Splits a slot number below 24 into bit index and phase (slot / 3 and slot % 3).
  function automatic bitpos_t split3(input logic [4:0] v);
    logic [2:0] q;
    logic [4:0] r;
    bitpos_t    p;
    q = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if ({1'b0, v} >= 6'(3 * k)) begin
        q = 3'(k);
      end
    end
    r = v - 5'(3 * q);
    p.bit_idx = q;
    p.phase   = r[1:0];
    return p;
  endfunction

  logic [2:0]  cmd_q, cmd_d;
  logic [4:0]  slot_q, slot_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [7:0]  tx_q, tx_d;

  logic [15:0] eff_ticks;
  logic [4:0]  slot_nxt;
  logic [4:0]  total;
  logic        run;
  logic        done;
  bitpos_t     wpos;
  bitpos_t     rpos;

  assign eff_ticks = (delay_ticks_i == 16'd0) ? 16'd1 : delay_ticks_i;
  assign slot_nxt  = slot_q + 5'd1;

  always_comb begin
    case (cmd_q)
      i2c_mbe_pkg::CMD_START, i2c_mbe_pkg::CMD_STOP: total = i2c_mbe_pkg::SLOTS_START_STOP;
      i2c_mbe_pkg::CMD_WRITE: total = i2c_mbe_pkg::SLOTS_WRITE;
      default: total = i2c_mbe_pkg::SLOTS_READ;
    endcase
  end

  // Timing: pick the next command, slot and tick count.
  always_comb begin
    cmd_d  = cmd_q;
    slot_d = slot_q;
    tick_d = tick_q;
    tx_d   = tx_q;
    run    = 1'b0;
    done   = 1'b0;
    if (cmd_q == i2c_mbe_pkg::CMD_IDLE) begin
      if (item_i.mode >= i2c_mbe_pkg::CMD_START && item_i.mode <= i2c_mbe_pkg::CMD_READ_NAK) begin
        cmd_d  = item_i.mode;
        slot_d = 5'd0;
        tick_d = 16'd1;
        run    = 1'b1;
        if (item_i.mode == i2c_mbe_pkg::CMD_WRITE) begin
          tx_d = item_i.write_byte;
        end
      end
    end else if (tick_q < eff_ticks) begin
      tick_d = tick_q + 16'd1;
    end else if (slot_nxt >= total) begin
      cmd_d  = i2c_mbe_pkg::CMD_IDLE;
      slot_d = 5'd0;
      tick_d = 16'd0;
      done   = 1'b1;
    end else begin
      slot_d = slot_nxt;
      tick_d = 16'd1;
      run    = 1'b1;
    end
  end

  assign wpos = split3(slot_d);
  assign rpos = split3(slot_d - 5'd1);

  // Pin action at the first tick of a slot.
  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    shift_d = shift_q;
    if (run) begin
      case (cmd_d)
        i2c_mbe_pkg::CMD_START: begin
          if (slot_d == 5'd0) begin
            scl_d = 1'b1;
            sda_d = 1'b1;
          end else if (slot_d == 5'd1) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        i2c_mbe_pkg::CMD_STOP: begin
          if (slot_d == 5'd0) begin
            scl_d = 1'b0;
            sda_d = 1'b0;
          end else if (slot_d == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        i2c_mbe_pkg::CMD_WRITE: begin
          if (slot_d < i2c_mbe_pkg::SLOT_WR_RELEASE) begin
            if (wpos.phase == 2'd0) begin
              sda_d = tx_d[~wpos.bit_idx];
            end else if (wpos.phase == 2'd1) begin
              scl_d = 1'b1;
            end else begin
              scl_d = 1'b0;
            end
          end else if (slot_d == i2c_mbe_pkg::SLOT_WR_RELEASE) begin
            sda_d = 1'b1;
          end else if (slot_d == i2c_mbe_pkg::SLOT_WR_ACK) begin
            scl_d = 1'b1;
            ack_d = ~item_i.sda_in;
          end else begin
            scl_d = 1'b0;
          end
        end
        default: begin
          if (slot_d == 5'd0) begin
            sda_d = 1'b1;
          end else if (slot_d <= i2c_mbe_pkg::SLOT_RD_LAST) begin
            if (rpos.phase == 2'd0) begin
              scl_d = 1'b1;
            end else if (rpos.phase == 2'd1) begin
              shift_d[~rpos.bit_idx] = item_i.sda_in;
            end else begin
              scl_d = 1'b0;
            end
          end else if (slot_d == i2c_mbe_pkg::SLOT_RD_ACK) begin
            sda_d = (cmd_d == i2c_mbe_pkg::CMD_READ_ACK) ? 1'b0 : 1'b1;
          end else if (slot_d == i2c_mbe_pkg::SLOT_RD_CLK_HI) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= i2c_mbe_pkg::CMD_IDLE;
      slot_q  <= 5'd0;
      tick_q  <= 16'd0;
      shift_q <= 8'd0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      tx_q    <= 8'd0;
    end else if (en_i) begin
      cmd_q   <= cmd_d;
      slot_q  <= slot_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      tx_q    <= tx_d;
    end
  end

  assign res_o.scl_out   = scl_d;
  assign res_o.sda_out   = sda_d;
  assign res_o.busy_res  = (cmd_d != i2c_mbe_pkg::CMD_IDLE);
  assign res_o.done_res  = done;
  assign res_o.acked     = ack_d;
  assign res_o.read_byte = shift_d;

endmodule

// ===== hw/rtl/i2c_mbe_regs.sv =====
// Configuration register block of the I2C byte engine, reached over an APB-style port.
module i2c_mbe_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] delay_ticks_o
);

  logic [15:0] delay_q, delay_d;
  logic        hit;

  assign hit   = (paddr[2] == i2c_mbe_pkg::REG_DELAY_TICKS);
  assign pready = 1'b1;

  always_comb begin
    delay_d = delay_q;
    if (psel && penable && pwrite && hit) begin
      delay_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= i2c_mbe_pkg::DELAY_RESET;
    end else begin
      delay_q <= delay_d;
    end
  end

  assign prdata        = hit ? {16'd0, delay_q} : 32'd0;
  assign delay_ticks_o = delay_q;

endmodule

// ===== hw/rtl/i2c_master_byte_engine_core.sv =====
// Top level of the I2C byte engine: input register, pin sequencer and result register.
//
// This block is a bit-level I2C master that drives the SCL and SDA levels itself. Every
// input word is one tick: it may carry a command (start, stop, write a byte, read a byte
// and ACK it, read a byte and NAK it) and always carries the sampled SDA level. Each
// command runs through a fixed list of delay slots, and every slot lasts delay_ticks
// ticks (a value of zero acts as one); start and stop take 3 slots, a write 27 and a
// read 28, with bits sent and received MSB first. A command that arrives while another
// is still running is dropped. Every input word gives exactly one result word with the
// driven pin levels, the busy and done flags, the ACK seen after the last write and the
// byte shifted in by the last read. The engine takes one word per clock cycle while
// in_stall_o is low. A word is held in the input register, and the sequencer update
// moves its result word into the result register once that register is free. A stall
// on the result side holds both registers and reaches the input side in the same cycle
// only when both are full. The delay_ticks register sits at byte address 0 of the
// APB-style port, resets to 55, and should be written only while the engine is idle.
module i2c_master_byte_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  write_byte_i,
  input  logic        sda_in_i,
  // Result words.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        acked_o,
  output logic [7:0]  read_byte_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               in_valid_q, in_valid_d;
  i2c_mbe_pkg::item_t in_item_q;
  i2c_mbe_pkg::item_t in_item;
  logic               out_valid_q, out_valid_d;
  i2c_mbe_pkg::res_t  out_res_q;
  i2c_mbe_pkg::res_t  seq_res;
  logic               out_free;
  logic               step;
  logic [15:0]        delay_ticks;

  // The result register can take a new word when it is empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The input register holds its word only when the result register cannot take it.
  assign in_stall_o = in_valid_q && !out_free;
  // The sequencer advances exactly once per word that moves into the result register.
  assign step       = in_valid_q && out_free;

  assign in_item.mode       = mode_i;
  assign in_item.write_byte = write_byte_i;
  assign in_item.sda_in     = sda_in_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item;
    end
    if (step) begin
      out_res_q <= seq_res;
    end
  end

  i2c_mbe_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (step),
    .item_i        (in_item_q),
    .delay_ticks_i (delay_ticks),
    .res_o         (seq_res)
  );

  i2c_mbe_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .delay_ticks_o (delay_ticks)
  );

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = out_res_q.scl_out;
  assign sda_out_o   = out_res_q.sda_out;
  assign busy_res_o  = out_res_q.busy_res;
  assign done_res_o  = out_res_q.done_res;
  assign acked_o     = out_res_q.acked;
  assign read_byte_o = out_res_q.read_byte;

endmodule

// ===== hw/rtl/i2c_mbe_checker.sv =====
// Port-level checker of the I2C byte engine and its bind to the top level.
`include "assert_macros.svh"

module i2c_mbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        scl_out_o,
  input logic        sda_out_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic        acked_o,
  input logic [7:0]  read_byte_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // A word that completes a command never reports the engine as busy.
  `I2C_ASSERT_SAME(a_done_not_busy, out_valid_o && done_res_o, !busy_res_o)

  // The input side stalls only when a result word is waiting and stalled.
  `I2C_ASSERT_SAME(a_stall_source, in_stall_o, out_valid_o && out_stall_i)

  // A stalled result word stays put.
  `I2C_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable({scl_out_o, sda_out_o, busy_res_o,
                                           done_res_o, acked_o, read_byte_o}))

  // A write to the delay register is read back on the next cycle.
  `I2C_ASSERT_SAME(a_cfg_readback,
                   $past(rst_ni) && $past(psel && penable && pwrite && !paddr[2])
                   && !paddr[2],
                   prdata[15:0] == $past(pwdata[15:0]))

endmodule

bind i2c_master_byte_engine_core i2c_mbe_checker u_i2c_mbe_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the I2C master byte engine: directed table, then random traffic.
//
// Every word sent to the engine is one tick of the pin sequencer, and every accepted word
// produces exactly one result word. The testbench keeps its own model of the sequencer.
// The model is stepped once for each accepted input word, and the result word it predicts
// is queued. The result monitor pops the oldest prediction for each accepted result word and
// compares the pins, flags, ACK and read byte field by field.
//
// The run has three parts. First, a short directed table is walked. It checks the state
// after reset, sets the slot delay to zero (which acts as one), and then runs a start, a
// stop, a write of each extreme byte, and a read with ACK and with NAK. It also sends a
// command while busy, a command on the completion tick, and the two unused mode values.
// Second, random phases run with different slot delays, and with sender gaps turned on or
// off. Most of the traffic is well-formed transactions (start, address write, data writes
// and reads, stop) with random bytes and random SDA samples. It is mixed with idle ticks,
// unused modes, commands thrown at a busy engine, and broken command lists. Third, the
// largest delay is set and a short run starts a command that never finishes in the run.
module tb_top;

  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         PHASE_WORDS    = 250;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_RUNS} stall_style_e;

  // One row of the directed table. A row either writes the delay register (cfg set) or sends
  // the same input word reps times. When typed is set, the result word of the row is
  // checked against want instead of the prediction.
  typedef struct packed {
    logic              cfg;
    logic [31:0]       cfg_val;
    logic [2:0]        mode;
    logic [7:0]        wbyte;
    logic              sda;
    logic [5:0]        reps;
    logic              typed;
    i2c_mbe_pkg::res_t want;
  } dir_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i       = i2c_mbe_pkg::CMD_IDLE;
  logic [7:0]  write_byte_i = 8'h00;
  logic        sda_in_i     = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        acked_o;
  logic [7:0]  read_byte_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_engine_core uut (.*);

  // The clock period is two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model of the sequencer. These start at the reset values of the engine.
  logic [15:0] delay_cfg = i2c_mbe_pkg::DELAY_RESET;
  logic [2:0]  run_cmd   = i2c_mbe_pkg::CMD_IDLE;
  logic [4:0]  slot_no   = '0;
  logic [15:0] tick_no   = '0;
  logic [7:0]  rx_shift  = '0;
  logic        ack_seen  = 1'b0;
  logic        scl_lvl   = 1'b1;
  logic        sda_lvl   = 1'b1;
  logic [7:0]  tx_hold   = '0;

  i2c_mbe_pkg::res_t pin_words_q[$];   // predicted result words, oldest first
  dir_row_t          dir_q[$];
  logic [2:0]        cmd_plan_q[$];    // commands waiting to be issued by the random traffic
  int                n_err      = 0;
  int                burst_left = 0;
  bit                gaps_on    = 1'b1;
  int                cyc        = 0;

  // This applies the pin action of the current slot, at the first tick of the slot.
  function automatic void apply_slot(input logic sda_s);
    logic [2:0] b;
    logic [4:0] ph;
    if (run_cmd == i2c_mbe_pkg::CMD_START) begin
      if (slot_no == 5'd0) begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
      end else if (slot_no == 5'd1) sda_lvl = 1'b0;
      else scl_lvl = 1'b0;
    end else if (run_cmd == i2c_mbe_pkg::CMD_STOP) begin
      if (slot_no == 5'd0) begin
        scl_lvl = 1'b0;
        sda_lvl = 1'b0;
      end else if (slot_no == 5'd1) scl_lvl = 1'b1;
      else sda_lvl = 1'b1;
    end else if (run_cmd == i2c_mbe_pkg::CMD_WRITE) begin
      if (slot_no < i2c_mbe_pkg::SLOT_WR_RELEASE) begin
        // Each data bit takes three slots: set SDA, raise SCL, then lower SCL.
        b  = 3'(slot_no / 5'd3);
        ph = slot_no % 5'd3;
        if (ph == 5'd0) sda_lvl = tx_hold[7 - b];
        else if (ph == 5'd1) scl_lvl = 1'b1;
        else scl_lvl = 1'b0;
      end else if (slot_no == i2c_mbe_pkg::SLOT_WR_RELEASE) sda_lvl = 1'b1;
      else if (slot_no == i2c_mbe_pkg::SLOT_WR_ACK) begin
        scl_lvl  = 1'b1;
        ack_seen = !sda_s;
      end else scl_lvl = 1'b0;
    end else begin
      // Reads first release SDA, then clock in eight bits, then drive ACK or NAK.
      if (slot_no == 5'd0) sda_lvl = 1'b1;
      else if (slot_no <= i2c_mbe_pkg::SLOT_RD_LAST) begin
        b  = 3'((slot_no - 5'd1) / 5'd3);
        ph = (slot_no - 5'd1) % 5'd3;
        if (ph == 5'd0) scl_lvl = 1'b1;
        else if (ph == 5'd1) rx_shift[7 - b] = sda_s;
        else scl_lvl = 1'b0;
      end else if (slot_no == i2c_mbe_pkg::SLOT_RD_ACK) begin
        sda_lvl = (run_cmd == i2c_mbe_pkg::CMD_READ_ACK) ? 1'b0 : 1'b1;
      end else if (slot_no == i2c_mbe_pkg::SLOT_RD_CLK_HI) scl_lvl = 1'b1;
      else scl_lvl = 1'b0;
    end
  endfunction

  // This advances the sequencer model by one tick and returns the result word it predicts.
  function automatic i2c_mbe_pkg::res_t engine_tick(input i2c_mbe_pkg::item_t it);
    logic [15:0]       eff;
    logic [4:0]        n_slots;
    i2c_mbe_pkg::res_t r;
    logic              done;
    eff  = (delay_cfg == 16'd0) ? 16'd1 : delay_cfg;
    done = 1'b0;
    if (run_cmd == i2c_mbe_pkg::CMD_IDLE) begin
      // Only an idle engine takes a command. Modes 6 and 7 are not commands.
      if (it.mode >= i2c_mbe_pkg::CMD_START && it.mode <= i2c_mbe_pkg::CMD_READ_NAK) begin
        run_cmd = it.mode;
        if (it.mode == i2c_mbe_pkg::CMD_WRITE) tx_hold = it.write_byte;
        slot_no = '0;
        tick_no = 16'd1;
        apply_slot(it.sda_in);
      end
    end else if (tick_no < eff) begin
      tick_no = tick_no + 16'd1;
    end else begin
      slot_no = slot_no + 5'd1;
      if (run_cmd == i2c_mbe_pkg::CMD_WRITE) n_slots = i2c_mbe_pkg::SLOTS_WRITE;
      else if (run_cmd == i2c_mbe_pkg::CMD_START || run_cmd == i2c_mbe_pkg::CMD_STOP) begin
        n_slots = i2c_mbe_pkg::SLOTS_START_STOP;
      end else n_slots = i2c_mbe_pkg::SLOTS_READ;
      if (slot_no >= n_slots) begin
        run_cmd = i2c_mbe_pkg::CMD_IDLE;
        slot_no = '0;
        tick_no = '0;
        done    = 1'b1;
      end else begin
        tick_no = 16'd1;
        apply_slot(it.sda_in);
      end
    end
    r.scl_out   = scl_lvl;
    r.sda_out   = sda_lvl;
    r.busy_res  = (run_cmd != i2c_mbe_pkg::CMD_IDLE);
    r.done_res  = done;
    r.acked     = ack_seen;
    r.read_byte = rx_shift;
    return r;
  endfunction

  task automatic add_row(input logic cfg, input logic [31:0] cfg_val, input logic [2:0] mode,
                         input logic [7:0] wbyte, input logic sda, input int reps,
                         input logic typed, input i2c_mbe_pkg::res_t want);
    dir_row_t row;
    row.cfg     = cfg;
    row.cfg_val = cfg_val;
    row.mode    = mode;
    row.wbyte   = wbyte;
    row.sda     = sda;
    row.reps    = 6'(reps);
    row.typed   = typed;
    row.want    = want;
    dir_q.push_back(row);
  endtask

  // This sends one input word and records its prediction once the word is taken. The sender
  // works in bursts. Between bursts it drops valid for a random gap, unless gaps are off.
  task automatic send_word(input i2c_mbe_pkg::item_t it, input logic typed,
                           input i2c_mbe_pkg::res_t want);
    i2c_mbe_pkg::res_t p;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left   = burst_left - 1;
    in_valid_i   <= 1'b1;
    mode_i       <= it.mode;
    write_byte_i <= it.write_byte;
    sda_in_i     <= it.sda_in;
    do @(posedge clk_i); while (in_stall_o);
    p = engine_tick(it);
    pin_words_q.push_back(typed ? want : p);
  endtask

  // This stops sending and waits until every predicted result word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pin_words_q.size() != 0) @(posedge clk_i);
  endtask

  // This writes the delay register through the APB port: a setup cycle, then an access cycle.
  // Only the low 16 bits are kept, so the upper bits carry junk on purpose.
  task automatic write_delay(input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {i2c_mbe_pkg::REG_DELAY_TICKS, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    delay_cfg = val[15:0];
  endtask

  // This queues the next batch of commands. Most batches are proper transactions. The rest
  // are short runs of arbitrary commands, such as a stop with no start or reads out of place.
  task automatic plan_commands();
    int n;
    n = $urandom_range(0, 3);
    if ($urandom_range(0, 4) != 0) begin
      cmd_plan_q.push_back(i2c_mbe_pkg::CMD_START);
      cmd_plan_q.push_back(i2c_mbe_pkg::CMD_WRITE);
      repeat (n) begin
        cmd_plan_q.push_back($urandom_range(0, 1) ? i2c_mbe_pkg::CMD_WRITE
                                                  : i2c_mbe_pkg::CMD_READ_ACK);
      end
      cmd_plan_q.push_back($urandom_range(0, 1) ? i2c_mbe_pkg::CMD_READ_NAK
                                                : i2c_mbe_pkg::CMD_WRITE);
      cmd_plan_q.push_back(i2c_mbe_pkg::CMD_STOP);
    end else begin
      repeat (n + 1) begin
        cmd_plan_q.push_back(3'($urandom_range(i2c_mbe_pkg::CMD_START,
                                               i2c_mbe_pkg::CMD_READ_NAK)));
      end
    end
  endtask

  // This sends random ticks. While the engine is busy, a tick now and then carries an
  // arbitrary mode, which the engine must drop. This includes the tick on which a command
  // completes.
  task automatic run_traffic(input int n_words);
    i2c_mbe_pkg::item_t it;
    int                 r;
    for (int i = 0; i < n_words; i++) begin
      it.write_byte = 8'($urandom);
      it.sda_in     = 1'($urandom);
      if (run_cmd != i2c_mbe_pkg::CMD_IDLE) begin
        it.mode = ($urandom_range(0, 5) == 0) ? 3'($urandom) : i2c_mbe_pkg::CMD_IDLE;
      end else begin
        if (cmd_plan_q.size() == 0) plan_commands();
        r = $urandom_range(0, 9);
        if (r < 7) it.mode = cmd_plan_q.pop_front();
        else if (r < 9) it.mode = i2c_mbe_pkg::CMD_IDLE;
        else it.mode = $urandom_range(0, 1) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
      end
      send_word(it, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  // Result monitor and receiver stalls. The stall style is picked at random from four: no
  // stall, random stalls, alternating stall and no stall, or long runs of stall and no stall.
  stall_style_e      stall_style = STALL_NONE;
  int                stall_run   = 0;
  logic              stall_lvl   = 1'b0;
  i2c_mbe_pkg::res_t want_word;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pin_words_q.size() == 0) begin
        $error("result word arrived with no prediction pending");
        n_err++;
      end else begin
        want_word = pin_words_q.pop_front();
        check_field("scl_out", want_word.scl_out, scl_out_o);
        check_field("sda_out", want_word.sda_out, sda_out_o);
        check_field("busy_res", want_word.busy_res, busy_res_o);
        check_field("done_res", want_word.done_res, done_res_o);
        check_field("acked", want_word.acked, acked_o);
        check_field("read_byte", want_word.read_byte, read_byte_o);
      end
    end
    if (cyc % 128 == 0) stall_style = stall_style_e'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_TOGGLE: out_stall_i <= cyc[0];
      default: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 12);
          stall_lvl = !stall_lvl;
        end
        stall_run   = stall_run - 1;
        out_stall_i <= stall_lvl;
      end
    endcase
  end

  // This watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    i2c_mbe_pkg::item_t it;
    logic [15:0]        phase_delay[6];
    // Result word fields, in order: scl_out, sda_out, busy_res, done_res, acked, read_byte.
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 1, 1'b1,
            '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00});
    // A delay of zero behaves as one tick per slot, which makes each command short.
    add_row(1'b1, {16'hA5A5, 16'h0000}, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b0, 0, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_START, 8'h00, 1'b1, 1, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_WRITE, 8'h3C, 1'b0, 1, 1'b0, '0);   // dropped, busy
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 1, 1'b0, '0);
    // A stop on the tick the start completes is dropped as well.
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_STOP, 8'h00, 1'b0, 1, 1'b1,
            '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00});
    add_row(1'b0, '0, MODE_UNUSED_LO, 8'h00, 1'b0, 1, 1'b0, '0);
    add_row(1'b0, '0, MODE_UNUSED_HI, 8'hFF, 1'b1, 1, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_STOP, 8'h00, 1'b1, 1, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 2, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 1, 1'b1,
            '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00});
    // Write all ones while the slave holds SDA low, so the byte is acknowledged.
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_WRITE, 8'hFF, 1'b0, 1, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b0, 26, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b0, 1, 1'b1,
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00});
    // Write all zeros with SDA left high, so the byte is not acknowledged.
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_WRITE, 8'h00, 1'b1, 1, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 26, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 1, 1'b1,
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00});
    // Read all ones and ACK, then read all zeros and NAK.
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_READ_ACK, 8'h00, 1'b1, 1, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 27, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b1, 1, 1'b1,
            '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF});
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_READ_NAK, 8'h00, 1'b0, 1, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b0, 27, 1'b0, '0);
    add_row(1'b0, '0, i2c_mbe_pkg::CMD_IDLE, 8'h00, 1'b0, 1, 1'b1,
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[k]) begin
      if (dir_q[k].cfg) begin
        drain_results();
        write_delay(dir_q[k].cfg_val);
      end else begin
        it.mode       = dir_q[k].mode;
        it.write_byte = dir_q[k].wbyte;
        it.sda_in     = dir_q[k].sda;
        repeat (dir_q[k].reps) send_word(it, dir_q[k].typed, dir_q[k].want);
      end
    end

    // Random phases. Delays stay small so that many commands complete. The smallest legal
    // value and zero are among them. Each phase ends with the engine idle before the next
    // register write.
    phase_delay = '{16'd1, 16'd2, 16'd0, 16'd3, 16'($urandom_range(1, 5)), 16'd4};
    foreach (phase_delay[p]) begin
      drain_results();
      write_delay({16'($urandom), phase_delay[p]});
      gaps_on = $urandom_range(0, 2) != 0;
      run_traffic(PHASE_WORDS);
      it.mode       = i2c_mbe_pkg::CMD_IDLE;
      it.write_byte = 8'($urandom);
      while (run_cmd != i2c_mbe_pkg::CMD_IDLE) begin
        it.sda_in = 1'($urandom);
        send_word(it, 1'b0, '0);
      end
    end

    // At the largest delay, a command starts and is still running when the run ends.
    drain_results();
    write_delay(32'hFFFF_FFFF);
    gaps_on = 1'b1;
    run_traffic(40);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (n_err == 0 && pin_words_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
